// File: rtl/core/element_block_grouping_table_top_assert.svh
// Assertion macros for the element block grouping table.
// Used by element_block_grouping_table_top; needs a clk and an rst_n in scope.
`ifndef ELEMENT_BLOCK_GROUPING_TABLE_TOP_ASSERT_SVH
`define ELEMENT_BLOCK_GROUPING_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define EGT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("egt assertion failed");
// Check a property on every clock edge, reset included
`define EGT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("egt assertion failed");
`else
`define EGT_ASSERT(lbl, prop)
`define EGT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/core/egt_pkg.sv
// Shared types and constants for the element block grouping table.
// No dependencies; used by all modules in rtl/core.
package egt_pkg;

  localparam int MAX_BLOCKS  = 12;
  localparam int COUNT_WIDTH = 32;

  localparam int KEY_W  = 13;
  localparam int SLOT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int USED_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  typedef struct packed {
    logic       op;
    logic [3:0] nodes_per_element;
    logic [2:0] poly_order;
    logic [2:0] boundary_nodes;
    logic [2:0] topology_code;
  } egt_in_t;

  typedef struct packed {
    logic [3:0]  block_id;
    logic        new_block;
    logic [31:0] element_count;
    logic [5:0]  shape_count;
    logic [31:0] boundary_total;
    logic [1:0]  status;
  } egt_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } egt_state_t;

  typedef struct packed {
    logic load;    // capture the input request
    logic commit;  // update the tables and load the result register
  } egt_cmd_t;

endpackage

// File: rtl/core/egt_ctrl.sv
// Controller for the element block grouping table: request sequencing.
// Depends on egt_pkg.
module egt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output egt_pkg::egt_cmd_t cmd
);

  egt_pkg::egt_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                commit_ok;

  assign commit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      egt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = egt_pkg::ST_EXEC;
      end
      egt_pkg::ST_EXEC: begin
        if (commit_ok) state_nxt = egt_pkg::ST_IDLE;
      end
      default: state_nxt = egt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      egt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      egt_pkg::ST_EXEC: begin
        cmd.commit = commit_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/egt_dp.sv
// Datapath for the element block grouping table: key tables, counters, result.
// Depends on egt_pkg; driven by egt_ctrl commands.
module egt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  egt_pkg::egt_in_t  in_data,
  input  egt_pkg::egt_cmd_t cmd,
  output egt_pkg::egt_out_t out_data
);

  localparam int CW = egt_pkg::COUNT_WIDTH;
  localparam int NB = egt_pkg::MAX_BLOCKS;

  // Shape functions of a key, kept modulo 64
  function automatic logic [5:0] shape_of(input logic [3:0] nen, input logic [2:0] ord);
    logic [6:0] n;
    logic [6:0] h;
    n = {3'b000, nen};
    h = {3'b000, nen} + (({3'b000, nen} + 7'd1) >> 1);
    if (ord == 3'd2) begin
      n = n + h;
    end else if (ord == 3'd3) begin
      n = n + (h << 1);
      if (nen == 4'd4 || nen == 4'd5) begin
        n = n + 7'd4;
      end else if (nen == 4'd6) begin
        n = n + 7'd2;
      end
    end
    return n[5:0];
  endfunction

  egt_pkg::egt_in_t  req_r;
  egt_pkg::egt_out_t out_r, out_nxt;

  logic [egt_pkg::KEY_W-1:0]  keys_r   [2][NB];
  logic [CW-1:0]              counts_r [2][NB];
  logic [5:0]                 shapes_r [2][NB];
  logic [egt_pkg::USED_W-1:0] used_r   [2];
  logic [egt_pkg::USED_W-1:0] used_nxt;
  logic [31:0]                seen_r, seen_nxt;
  logic                       three_d_r;

  logic                       op;
  logic [2:0]                 topo;
  logic [egt_pkg::KEY_W-1:0]  key;
  logic [NB-1:0]              match;
  logic [egt_pkg::SLOT_W-1:0] hit_slot;
  logic [egt_pkg::SLOT_W-1:0] new_slot;
  logic                       found;
  logic                       full;
  logic                       order_bad;
  logic                       do_hit;
  logic                       do_alloc;
  logic [CW-1:0]              cnt_cur;
  logic [CW-1:0]              cnt_inc;
  logic [5:0]                 shp_new;

  assign op = req_r.op;

  // 3D boundary remap: wedge takes the boundary node count, a pyramid on a
  // triangular face becomes code 6
  always_comb begin
    topo = req_r.topology_code;
    if (op && three_d_r) begin
      if (topo == 3'd3) topo = req_r.boundary_nodes;
      if (topo == 3'd5 && req_r.boundary_nodes == 3'd3) topo = 3'd6;
    end
  end

  assign key = {req_r.nodes_per_element, req_r.poly_order, req_r.boundary_nodes, topo};

  // Keys in a table are unique, so at most one match: OR the indices together
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < NB; i++) begin
      match[i] = (egt_pkg::USED_W'(i) < used_r[op]) && (keys_r[op][i] == key);
      if (match[i]) hit_slot = hit_slot | egt_pkg::SLOT_W'(i);
    end
  end

  assign found     = |match;
  assign full      = (used_r[op] == egt_pkg::USED_W'(NB));
  assign order_bad = req_r.poly_order[2];
  assign do_hit    = !order_bad && found;
  assign do_alloc  = !order_bad && !found && !full;
  assign new_slot  = used_r[op][egt_pkg::SLOT_W-1:0];
  assign cnt_cur   = counts_r[op][hit_slot];
  assign cnt_inc   = (cnt_cur == {CW{1'b1}}) ? cnt_cur : cnt_cur + CW'(1);
  assign shp_new   = shape_of(req_r.nodes_per_element, req_r.poly_order);
  assign used_nxt  = do_alloc ? used_r[op] + egt_pkg::USED_W'(1) : used_r[op];

  always_comb begin
    seen_nxt = seen_r;
    if (op && (do_hit || do_alloc) && seen_r != 32'hFFFF_FFFF) seen_nxt = seen_r + 32'd1;
  end

  always_comb begin
    out_nxt                = '0;
    out_nxt.boundary_total = seen_nxt;
    priority if (order_bad) begin
      out_nxt.status = egt_pkg::STATUS_ORDER;
    end else if (found) begin
      out_nxt.status        = egt_pkg::STATUS_OK;
      out_nxt.block_id      = 4'(egt_pkg::USED_W'(hit_slot) + egt_pkg::USED_W'(1));
      out_nxt.element_count = 32'(cnt_inc);
      out_nxt.shape_count   = shapes_r[op][hit_slot];
    end else if (full) begin
      out_nxt.status = egt_pkg::STATUS_FULL;
    end else begin
      out_nxt.status        = egt_pkg::STATUS_OK;
      out_nxt.block_id      = 4'(used_r[op] + egt_pkg::USED_W'(1));
      out_nxt.new_block     = 1'b1;
      out_nxt.element_count = 32'(CW'(1));
      out_nxt.shape_count   = shp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r[0] <= '0;
      used_r[1] <= '0;
      seen_r    <= '0;
      three_d_r <= 1'b1;
    end else begin
      if (cfg_we) three_d_r <= cfg_wdata;
      if (cmd.commit) begin
        used_r[op] <= used_nxt;
        seen_r     <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.commit) begin
      out_r <= out_nxt;
      if (do_hit) counts_r[op][hit_slot] <= cnt_inc;
      if (do_alloc) begin
        keys_r[op][new_slot]   <= key;
        counts_r[op][new_slot] <= CW'(1);
        shapes_r[op][new_slot] <= shp_new;
      end
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/element_block_grouping_table_top.sv
// Top level of the element block grouping table.
// Depends on egt_pkg, egt_ctrl, egt_dp and element_block_grouping_table_top_assert.svh.
//
//   channel  ports                          payload
//   -------  -----------------------------  ------------------------------
//   input    in_valid / in_ready / in_data   egt_in_t: one element request
//   result   out_valid / out_ready / out_data egt_out_t: one result per request
//   config   cfg_we / cfg_wdata              three_d_mode, written at once
//
// Each request is first captured into the request register; then the
// twelve-way key compare, the count update and the result load follow.
// The next request is taken while a result still waits in the output register;
// the update step then holds until that result is taken.
// Synchronous active-low reset empties both tables, clears the boundary total
// and sets three_d_mode; there is no clearing pass.
`include "element_block_grouping_table_top_assert.svh"

module element_block_grouping_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  egt_pkg::egt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output egt_pkg::egt_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  egt_pkg::egt_cmd_t cmd;

  // Sequence each request: capture, then update once the result slot is free
  egt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold the tables, the boundary total and the result register
  egt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

  // A result only appears after an update
  `EGT_ASSERT(a_valid_after_commit, $rose(out_valid) |-> $past(cmd.commit))
  // Never overwrite a result that is still waiting
  `EGT_ASSERT(a_no_overwrite, cmd.commit |-> (!out_valid || out_ready))
  // An accepted request blocks the input until it is processed
  `EGT_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
  // Update and capture never happen together
  `EGT_ASSERT_ALWAYS(a_cmd_exclusive, !(cmd.load && cmd.commit))

endmodule
